### src/gci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gci_pkg
// Shared constants and types for the grid crossing interpolator.
// ----------------------------------------------------------------------------
package gci_pkg;

  // Default width of the signed Q16.16 value, threshold and coordinate fields
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Status of a bit-serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### src/gci_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gci_in_if
// Grid point channel: sample, threshold, coordinate and row end marker.
// ----------------------------------------------------------------------------
interface gci_in_if import gci_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample_value;
  logic signed [DATA_WIDTH-1:0] threshold_value;
  logic signed [DATA_WIDTH-1:0] grid_coordinate;
  logic                         last_point;

  modport source (
    output valid, sample_value, threshold_value, grid_coordinate, last_point,
    input  ready
  );

  modport sink (
    input  valid, sample_value, threshold_value, grid_coordinate, last_point,
    output ready
  );
endinterface

### src/gci_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gci_out_if
// Result channel: crossing coordinate and found flag, one per row.
// ----------------------------------------------------------------------------
interface gci_out_if import gci_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] crossing_coordinate;
  logic                         root_found;

  modport source (
    output valid, crossing_coordinate, root_found,
    input  ready
  );

  modport sink (
    input  valid, crossing_coordinate, root_found,
    output ready
  );
endinterface

### src/gci_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gci_mul
// Bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module gci_mul import gci_pkg::*; #(
  parameter int unsigned OP_WIDTH = DATA_WIDTH_DEF + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [OP_WIDTH-1:0]     a_i,
  input  logic [OP_WIDTH-1:0]     b_i,
  output logic [2*OP_WIDTH-1:0]   prod_o,
  output unit_stat_t              stat_o
);

  localparam int unsigned CNT_WIDTH = $clog2(OP_WIDTH);

  logic                  busy_q, done_q;
  logic [CNT_WIDTH-1:0]  cnt_q;
  logic [OP_WIDTH-1:0]   mcand_q;
  logic [2*OP_WIDTH-1:0] prod_q;
  logic [OP_WIDTH:0]     sum;

  // upper half accumulates, multiplier bits leave through the bottom
  assign sum = {1'b0, prod_q[2*OP_WIDTH-1:OP_WIDTH]}
             + (prod_q[0] ? {1'b0, mcand_q} : {(OP_WIDTH + 1){1'b0}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_WIDTH'(OP_WIDTH - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= a_i;
      prod_q  <= {{OP_WIDTH{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[OP_WIDTH-1:1]};
    end
  end

  assign prod_o      = prod_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### src/gci_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gci_div
// Bit-serial restoring divider, one dividend bit per cycle, floor quotient.
// ----------------------------------------------------------------------------
module gci_div import gci_pkg::*; #(
  parameter int unsigned DEN_WIDTH = DATA_WIDTH_DEF + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [2*DEN_WIDTH-1:0]   num_i,
  input  logic [DEN_WIDTH-1:0]     den_i,
  output logic [DEN_WIDTH-1:0]     quo_o,
  output unit_stat_t               stat_o
);

  localparam int unsigned NUM_WIDTH = 2 * DEN_WIDTH;
  localparam int unsigned CNT_WIDTH = $clog2(NUM_WIDTH);

  logic                  busy_q, done_q;
  logic [CNT_WIDTH-1:0]  cnt_q;
  logic [NUM_WIDTH-1:0]  num_q;
  logic [DEN_WIDTH-1:0]  den_q;
  logic [DEN_WIDTH-1:0]  rem_q;
  logic [DEN_WIDTH-1:0]  quo_q;
  logic [DEN_WIDTH:0]    trial;
  logic [DEN_WIDTH:0]    trial_sub;
  logic                  fits;

  assign trial     = {rem_q, num_q[NUM_WIDTH-1]};
  assign fits      = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_WIDTH'(NUM_WIDTH - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // the remainder stays below the divisor, so it fits DEN_WIDTH bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_WIDTH-2:0], 1'b0};
      rem_q <= fits ? trial_sub[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
      quo_q <= {quo_q[DEN_WIDTH-2:0], fits};
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### src/grid_crossing_interpolator.sv
`timescale 1ns / 1ps
// Row end results are registered: when the last point needs no interpolation, the result
//   is valid in the cycle after that point is accepted.
// The point that interpolates the crossing runs the bit-serial multiplier, then the
//   divider; no point is taken meanwhile. Otherwise one point per cycle, but a row
//   end waits for a free output slot. At most one interpolation per row.
// Reset (async, active low) clears row state and empties the output register.
// ----------------------------------------------------------------------------
// grid_crossing_interpolator
// Finds the first threshold crossing of a row and interpolates its abscissa.
// ----------------------------------------------------------------------------
module grid_crossing_interpolator import gci_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gci_in_if.sink     in_i,
  gci_out_if.source  out_o
);

  localparam int unsigned OP_WIDTH = DATA_WIDTH + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [DATA_WIDTH+1:0] SAT_MAX = {3'b000, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic [DATA_WIDTH+1:0] SAT_MIN = {3'b111, {(DATA_WIDTH - 1){1'b0}}};

  logic [1:0]            state_q, state_d;
  logic [DATA_WIDTH:0]   prev_diff_q, prev_diff_d;
  logic [DATA_WIDTH-1:0] prev_coord_q, prev_coord_d;
  logic                  row_start_q, row_start_d;
  logic                  seen_q, seen_d;
  logic [DATA_WIDTH-1:0] held_q, held_d;
  logic                  last_pend_q, last_pend_d;
  logic                  dx_neg_q, dx_neg_d;
  logic [DATA_WIDTH:0]   den_q, den_d;
  logic                  out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] out_coord_q, out_coord_d;
  logic                  out_found_q, out_found_d;

  logic                    in_acc;
  logic                    go_interp;
  logic                    load_out;
  logic                    clear_row;
  logic                    mul_start, div_start;
  logic [DATA_WIDTH:0]     diff_w, dx_w, mag, num;
  logic [DATA_WIDTH+1:0]   den_w;
  logic [2*OP_WIDTH-1:0]   prod;
  logic [DATA_WIDTH:0]     quo;
  logic [DATA_WIDTH+1:0]   base_x, off_x, res_w;
  logic [DATA_WIDTH-1:0]   res_sat;
  unit_stat_t              mul_stat, div_stat;

  assign in_acc = in_i.valid && in_i.ready;

  // difference and step to the previous point, one bit of headroom
  assign diff_w = {in_i.sample_value[DATA_WIDTH-1], in_i.sample_value}
                - {in_i.threshold_value[DATA_WIDTH-1], in_i.threshold_value};
  assign dx_w   = {in_i.grid_coordinate[DATA_WIDTH-1], in_i.grid_coordinate}
                - {prev_coord_q[DATA_WIDTH-1], prev_coord_q};
  assign mag    = dx_w[DATA_WIDTH] ? (~dx_w + 1'b1) : dx_w;
  assign num    = ~prev_diff_q + 1'b1;
  assign den_w  = {diff_w[DATA_WIDTH], diff_w} - {prev_diff_q[DATA_WIDTH], prev_diff_q};

  gci_mul #(
    .OP_WIDTH (OP_WIDTH)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mag),
    .b_i     (num),
    .prod_o  (prod),
    .stat_o  (mul_stat)
  );

  gci_div #(
    .DEN_WIDTH (OP_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod),
    .den_i   (den_q),
    .quo_o   (quo),
    .stat_o  (div_stat)
  );

  // offset never exceeds |dx|, so the sum lands between the two coordinates
  assign base_x = {{2{prev_coord_q[DATA_WIDTH-1]}}, prev_coord_q};
  assign off_x  = {1'b0, quo};
  assign res_w  = dx_neg_q ? (base_x - off_x) : (base_x + off_x);

  always_comb begin
    priority if ($signed(res_w) > $signed(SAT_MAX)) begin
      res_sat = SAT_MAX[DATA_WIDTH-1:0];
    end else if ($signed(res_w) < $signed(SAT_MIN)) begin
      res_sat = SAT_MIN[DATA_WIDTH-1:0];
    end else begin
      res_sat = res_w[DATA_WIDTH-1:0];
    end
  end

  // a row end needs the output slot; other points may pass a pending result
  assign in_i.ready = (state_q == ST_IDLE)
                   && (!out_valid_q || out_o.ready || !in_i.last_point);

  always_comb begin
    state_d      = state_q;
    prev_diff_d  = prev_diff_q;
    prev_coord_d = prev_coord_q;
    row_start_d  = row_start_q;
    seen_d       = seen_q;
    held_d       = held_q;
    last_pend_d  = last_pend_q;
    dx_neg_d     = dx_neg_q;
    den_d        = den_q;
    go_interp    = 1'b0;
    load_out     = 1'b0;
    clear_row    = 1'b0;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    out_coord_d  = held_q;
    out_found_d  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!seen_q) begin
            if (!diff_w[DATA_WIDTH]) begin
              if (row_start_q) begin
                held_d = in_i.grid_coordinate;
                seen_d = 1'b1;
              end else begin
                go_interp   = 1'b1;
                mul_start   = 1'b1;
                den_d       = den_w[DATA_WIDTH:0];
                dx_neg_d    = dx_w[DATA_WIDTH];
                last_pend_d = in_i.last_point;
                state_d     = ST_MUL;
              end
            end else begin
              prev_diff_d  = diff_w;
              prev_coord_d = in_i.grid_coordinate;
              row_start_d  = 1'b0;
            end
          end
          if (in_i.last_point && !go_interp) begin
            load_out    = 1'b1;
            clear_row   = 1'b1;
            out_coord_d = seen_q ? held_q : in_i.grid_coordinate;
            out_found_d = seen_q || !diff_w[DATA_WIDTH];
          end
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          held_d  = res_sat;
          seen_d  = 1'b1;
          state_d = last_pend_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out  = 1'b1;
          clear_row = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (clear_row) begin
      prev_diff_d  = '0;
      prev_coord_d = '0;
      row_start_d  = 1'b1;
      seen_d       = 1'b0;
      held_d       = '0;
    end
  end

  assign out_valid_d = load_out ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_diff_q  <= '0;
      prev_coord_q <= '0;
      row_start_q  <= 1'b1;
      seen_q       <= 1'b0;
      held_q       <= '0;
      last_pend_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_diff_q  <= prev_diff_d;
      prev_coord_q <= prev_coord_d;
      row_start_q  <= row_start_d;
      seen_q       <= seen_d;
      held_q       <= held_d;
      last_pend_q  <= last_pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_neg_q <= dx_neg_d;
    den_q    <= den_d;
    if (load_out) begin
      out_coord_q <= out_coord_d;
      out_found_q <= out_found_d;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.crossing_coordinate = out_coord_q;
  assign out_o.root_found          = out_found_q;

  // input is only taken while no interpolation is in flight
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (state_q == ST_IDLE))
    else $error("input ready outside idle");

  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_stat.done |-> (state_q == ST_MUL) && !div_stat.busy)
    else $error("multiplier finished outside multiply phase");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV) && !mul_stat.busy)
    else $error("divider finished outside divide phase");

  // an interpolation always ends with the crossing recorded
  a_seen_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && div_stat.done |=> seen_q)
    else $error("crossing not recorded after interpolation");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of grid_crossing_interpolator. Rows of grid points are
// streamed in, directed first and then random, with random gaps on the point
// channel and random stalls on the result channel. Each result is compared
// with an independent Q16.16 crossing predictor.
// ----------------------------------------------------------------------------
module testbench;
  import gci_pkg::*;

  localparam int unsigned DW         = DATA_WIDTH_DEF;
  localparam int          CLK_PERIOD = 20;
  localparam int          CYCLE_LIMIT = 1_000_000;
  // longest point (bit-serial multiply + divide) plus margin
  localparam int          DRAIN_CYCLES = 3 * DW + 16;

  localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  typedef struct {
    logic signed [DW-1:0] sample;
    logic signed [DW-1:0] threshold;
    logic signed [DW-1:0] coord;
    logic                 last;
  } grid_point_t;

  typedef struct {
    logic signed [DW-1:0] coord;
    logic                 found;
  } crossing_result_t;

  logic clk_i;
  logic rst_ni;

  gci_in_if  #(.DATA_WIDTH(DW)) pt_if  ();
  gci_out_if #(.DATA_WIDTH(DW)) res_if ();

  grid_crossing_interpolator #(.DATA_WIDTH(DW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pt_if),
    .out_o  (res_if)
  );

  // predictor row state
  logic signed [DW:0]   prev_diff;
  logic signed [DW-1:0] prev_coord;
  logic signed [DW-1:0] held_coord;
  bit                   at_row_start;
  bit                   crossing_seen;

  crossing_result_t crossing_queue[$];
  int               error_count;
  int               points_sent;
  int               cycle_count;
  int               stall_left;
  bit               idle_on;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  function automatic void clear_row_state();
    prev_diff     = '0;
    prev_coord    = '0;
    held_coord    = '0;
    at_row_start  = 1'b1;
    crossing_seen = 1'b0;
  endfunction

  // Expected crossing for one accepted point; queues a result at row end.
  function automatic void predict_crossing(input grid_point_t p);
    logic signed [DW:0]     diff;
    logic signed [DW+1:0]   dx;
    logic [DW+1:0]          dx_mag;
    logic [DW+1:0]          g_mag;
    logic [DW+1:0]          span;
    logic [2*DW+3:0]        offset;
    logic signed [DW+2:0]   off_s;
    logic signed [DW+2:0]   r;
    crossing_result_t       res;
    diff = p.sample - p.threshold;
    if (!crossing_seen) begin
      if (diff >= 0) begin
        if (at_row_start) begin
          held_coord = p.coord;
        end else begin
          dx     = p.coord - prev_coord;
          dx_mag = (dx < 0) ? -dx : dx;
          g_mag  = (prev_diff < 0) ? -prev_diff : prev_diff;
          span   = diff - prev_diff;
          if (span == 0) span = 1;
          offset = (dx_mag * g_mag) / span;
          if (offset > dx_mag) offset = dx_mag;
          off_s = $signed({1'b0, offset[DW+1:0]});
          r = (dx < 0) ? prev_coord - off_s : prev_coord + off_s;
          if (r > MAXV) r = MAXV;
          if (r < MINV) r = MINV;
          held_coord = r[DW-1:0];
        end
        crossing_seen = 1'b1;
      end else begin
        prev_diff    = diff;
        prev_coord   = p.coord;
        at_row_start = 1'b0;
      end
    end
    if (p.last) begin
      res.coord = crossing_seen ? held_coord : p.coord;
      res.found = crossing_seen;
      crossing_queue.push_back(res);
      clear_row_state();
    end
  endfunction

  function automatic grid_point_t pt(input logic signed [DW-1:0] s, input logic signed [DW-1:0] t,
                                     input logic signed [DW-1:0] x, input logic last);
    grid_point_t p;
    p.sample    = s;
    p.threshold = t;
    p.coord     = x;
    p.last      = last;
    return p;
  endfunction

  // Called at a rising edge; returns at the edge where the point was taken.
  task automatic send_point(input grid_point_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pt_if.valid           <= 1'b1;
    pt_if.sample_value    <= p.sample;
    pt_if.threshold_value <= p.threshold;
    pt_if.grid_coordinate <= p.coord;
    pt_if.last_point      <= p.last;
    @(posedge clk_i);
    while (!pt_if.ready) @(posedge clk_i);
    predict_crossing(p);
    points_sent++;
  endtask

  function automatic logic signed [DW-1:0] rand_word();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) return $urandom;
    if (mode < 8) return ($signed($urandom_range(0, 2048)) - 1024) <<< 12;
    if (mode == 8) begin
      case ($urandom_range(0, 3))
        0: return MAXV;
        1: return MINV;
        2: return '0;
        default: return '1;
      endcase
    end
    return $signed($urandom_range(0, 15)) - 8;
  endfunction

  // Pick sample and threshold so that their difference has the wanted sign.
  task automatic pick_pair(input bit want_neg, output logic signed [DW-1:0] s,
                           output logic signed [DW-1:0] t);
    logic signed [DW-1:0] tmp;
    s = rand_word();
    t = rand_word();
    if (want_neg) begin
      if (s > t) begin
        tmp = s; s = t; t = tmp;
      end
      if (s == t) begin
        if (s != MINV) s = s - 1;
        else t = t + 1;
      end
    end else if (s < t) begin
      tmp = s; s = t; t = tmp;
    end
  endtask

  task automatic test_row_start_crossing();
    send_point(pt(0, 0, 32'h1234_0000, 1'b1));
    send_point(pt(MAXV, MINV, MINV, 1'b0));
    send_point(pt(-5, 5, 7, 1'b0));
    send_point(pt(32'h0001_0000, 32'h0001_0000, 9, 1'b0));
    send_point(pt(MINV, MAXV, MAXV, 1'b1));
  endtask

  task automatic test_no_crossing();
    send_point(pt(MINV, MAXV, 32'h0000_1000, 1'b0));
    send_point(pt(-1, 0, 32'h0000_2000, 1'b0));
    send_point(pt(MINV, MAXV, MAXV, 1'b1));
    send_point(pt(-1, 0, MINV, 1'b1));
  endtask

  task automatic test_interpolation_extremes();
    // widest difference swing across the widest coordinate span
    send_point(pt(MINV, MAXV, MINV, 1'b0));
    send_point(pt(MAXV, MINV, MAXV, 1'b1));
    // coordinates running backward
    send_point(pt(-32'sh0001_0000, 0, MAXV, 1'b0));
    send_point(pt(32'sh0003_0000, 0, MINV, 1'b0));
    send_point(pt(0, 0, 5, 1'b1));
    // difference lands exactly on zero
    send_point(pt(-3, 0, 0, 1'b0));
    send_point(pt(7, 7, 32'h0000_0100, 1'b1));
    // no coordinate step
    send_point(pt(-1, 0, 42, 1'b0));
    send_point(pt(1, 0, 42, 1'b1));
    // tiny negative then huge positive difference
    send_point(pt(-1, 0, 0, 1'b0));
    send_point(pt(MAXV, MINV, MAXV, 1'b1));
  endtask

  task automatic test_points_after_crossing();
    send_point(pt(-2, 0, 0, 1'b0));
    send_point(pt(2, 0, 4, 1'b0));
    send_point(pt(MINV, MAXV, 100, 1'b0));
    send_point(pt(MINV, MAXV, 200, 1'b1));
    // next row must start clean
    send_point(pt(5, 0, 9, 1'b1));
  endtask

  // Well-formed rows: negative differences up to a random crossing point.
  task automatic test_random_rows(input int n_points);
    int                   start;
    int                   len;
    int                   cross_at;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] s;
    logic signed [DW-1:0] t;
    start = points_sent;
    while (points_sent - start < n_points) begin
      idle_on  = ($urandom_range(0, 4) != 0);
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      cross_at = $urandom_range(0, len);
      x        = rand_word();
      for (int i = 0; i < len; i++) begin
        if (i < cross_at) pick_pair(1'b1, s, t);
        else if (i == cross_at) pick_pair(1'b0, s, t);
        else begin
          s = rand_word();
          t = rand_word();
        end
        send_point(pt(s, t, x, i == len - 1));
        case ($urandom_range(0, 7))
          0:       x = rand_word();
          1:       x = x - $signed($urandom_range(1, 32'h0004_0000));
          default: x = x + $signed($urandom_range(1, 32'h0004_0000));
        endcase
      end
    end
  endtask

  task automatic test_random_noise(input int n_points);
    int start;
    start = points_sent;
    while (points_sent - start < n_points) begin
      if ($urandom_range(0, 15) == 0) idle_on = ~idle_on;
      send_point(pt($urandom, $urandom, $urandom, $urandom_range(0, 4) == 0));
    end
  endtask

  // result channel stalls
  always @(posedge clk_i) begin : drive_result_ready
    int gap;
    if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      gap = pick_gap();
      res_if.ready <= (gap == 0);
      stall_left   <= (gap > 0) ? gap - 1 : 0;
    end
  end

  always @(posedge clk_i) begin : check_results
    crossing_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (crossing_queue.size() == 0) begin
        note_error($sformatf("unexpected result coord=%h found=%b",
                             res_if.crossing_coordinate, res_if.root_found));
      end else begin
        want = crossing_queue.pop_front();
        if (res_if.crossing_coordinate !== want.coord || res_if.root_found !== want.found)
          note_error($sformatf("mismatch: coord exp %h got %h, found exp %b got %b",
                               want.coord, res_if.crossing_coordinate,
                               want.found, res_if.root_found));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni                = 1'b0;
    pt_if.valid           = 1'b0;
    pt_if.sample_value    = '0;
    pt_if.threshold_value = '0;
    pt_if.grid_coordinate = '0;
    pt_if.last_point      = 1'b0;
    res_if.ready          = 1'b0;
    stall_left            = 0;
    idle_on               = 1'b1;
    error_count           = 0;
    points_sent           = 0;
    clear_row_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_row_start_crossing();
    test_no_crossing();
    test_interpolation_extremes();
    test_points_after_crossing();
    test_random_rows(900);
    test_random_noise(300);
    test_random_rows(500);

    pt_if.valid <= 1'b0;
    while (crossing_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (crossing_queue.size() != 0) note_error("results still pending at end");

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/gci_pkg.sv
src/gci_in_if.sv
src/gci_out_if.sv
src/gci_mul.sv
src/gci_div.sv
src/grid_crossing_interpolator.sv
tb/testbench.sv
